>>> design/wsmd_pkg.sv
package wsmd_pkg;

  localparam int unsigned SUM_W   = 36;
  localparam int unsigned DEN_W   = 5;
  localparam int unsigned DCNT_W  = 6;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_END    = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_HEADER   = 3'd0,
    ERR_MISSING  = 3'd1,
    ERR_METADATA = 3'd2,
    ERR_FORMAT   = 3'd3,
    ERR_BITS     = 3'd4,
    ERR_TRUNC    = 3'd5
  } err_e;

  typedef enum logic [6:0] {
    PH_HDR   = 7'b0000001,
    PH_CHDR  = 7'b0000010,
    PH_FMT   = 7'b0000100,
    PH_SKIP  = 7'b0001000,
    PH_PAD   = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_DRAIN = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic step;
    logic div_run;
  } cmd_t;

  typedef struct packed {
    logic div_need;
    logic div_done;
    logic out_full;
  } status_t;

endpackage

>>> design/wsmd_ctrl.sv
module wsmd_ctrl
  import wsmd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE) && !status_i.out_full;

  always_comb begin
    state_d       = state_q;
    cmd_o.step    = 1'b0;
    cmd_o.div_run = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.step = in_valid_i && in_ready_o;
        if (cmd_o.step && status_i.div_need) state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        if (status_i.div_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule

>>> design/wsmd_dp.sv
module wsmd_dp
  import wsmd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] mono_sample_o,
  output logic [31:0] rate_hz_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  function automatic logic signed [31:0] decode(input logic [31:0] raw,
                                                input logic [15:0] fmt,
                                                input logic [15:0] bits);
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic [31:0] mag;
    logic [7:0]  sh;
    e   = raw[30:23];
    m   = raw[22:0];
    sig = {1'b1, m};
    mag = '0;
    sh  = '0;
    if (fmt == FMT_FLOAT) begin
      if (e == 8'hFF && m != '0) return 32'sd0;
      if (e >= 8'd127) return raw[31] ? 32'h80000000 : 32'h7FFFFFFF;
      if (e == 8'd0) return 32'sd0;
      if (e >= 8'd119) begin
        mag = {8'd0, sig} << (e - 8'd119);
      end else begin
        sh  = 8'd119 - e;
        mag = (sh >= 8'd24) ? 32'd0 : ({8'd0, sig} >> sh);
      end
      return raw[31] ? -mag : mag;
    end
    if (bits == 16'd16) return {raw[15:0], 16'd0};
    if (bits == 16'd24) return {raw[23:0], 8'd0};
    return raw;
  endfunction

  phase_e                  ph_q, ph_d;
  logic [31:0]             bc_q, bc_d;
  logic [31:0]             len_q, len_d;
  logic [31:0]             tag_q, tag_d;
  logic [15:0]             fmt_q, fmt_d;
  logic [15:0]             chan_q, chan_d;
  logic [31:0]             rate_q, rate_d;
  logic [15:0]             frame_q, frame_d;
  logic [15:0]             bits_q, bits_d;
  logic                    seen_q, seen_d;
  logic [15:0]             off_q, off_d;
  logic [31:0]             asm_q, asm_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [1:0]              k_q, k_d;
  logic [7:0]              used_q, used_d;

  logic                    res_v, res_last, frame_done, frame_last;
  kind_e                   res_kind;
  err_e                    res_code;
  logic [31:0]             res_rate;
  logic signed [SUM_W-1:0] sum_fin;
  logic [2:0]              bps;
  logic [7:0]              used_new;
  logic                    div_req;

  logic [SUM_W-1:0]  dv_quo_q;
  logic [DEN_W:0]    dv_rem_q;
  logic [DEN_W-1:0]  dv_den_q;
  logic [DCNT_W-1:0] dv_cnt_q;
  logic              dv_neg_q, dv_last_q;
  logic [31:0]       dv_rate_q;
  logic [DEN_W+1:0]  dv_trial;
  logic              dv_bit;
  logic [SUM_W-1:0]  dv_quo_nx;
  logic [DEN_W:0]    dv_rem_nx;

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [31:0] mono_q, rate_out_q;
  logic [2:0]  code_q;
  logic        last_q;

  assign bps      = bits_q[5:3];
  assign used_new = 8'(chan_q[4:0]) * 8'(bps);

  always_comb begin
    ph_d = ph_q; bc_d = bc_q; len_d = len_q; tag_d = tag_q;
    fmt_d = fmt_q; chan_d = chan_q; rate_d = rate_q; frame_d = frame_q;
    bits_d = bits_q; seen_d = seen_q; off_d = off_q; asm_d = asm_q;
    sum_d = sum_q; k_d = k_q; used_d = used_q;
    res_v = 1'b0; res_kind = KIND_ERROR; res_code = ERR_HEADER;
    res_rate = '0; res_last = 1'b1;
    frame_done = 1'b0; frame_last = 1'b0; sum_fin = sum_q;
    case (ph_q)
      PH_HDR: begin
        tag_d = {tag_q[23:0], data_byte_i};
        bc_d  = bc_q + 32'd1;
        if (bc_q == 32'd3 && tag_d != TAG_RIFF) begin
          ph_d = PH_DRAIN; res_v = 1'b1; res_code = ERR_HEADER;
        end else if (bc_q == 32'd11) begin
          if (tag_d != TAG_WAVE) begin
            ph_d = PH_DRAIN; res_v = 1'b1; res_code = ERR_HEADER;
          end else begin
            ph_d = PH_CHDR; bc_d = '0;
          end
        end
      end
      PH_CHDR: begin
        bc_d = bc_q + 32'd1;
        if (bc_q < 32'd4) begin
          tag_d = {tag_q[23:0], data_byte_i};
        end else begin
          if (bc_q == 32'd4) len_d = {24'd0, data_byte_i};
          else len_d = len_q | ({24'd0, data_byte_i} << {bc_q[1:0], 3'b000});
          if (bc_q == 32'd7) begin
            bc_d = '0;
            if (tag_q == TAG_FMT) begin
              if (len_d < 32'd16) begin
                ph_d = PH_DRAIN; res_v = 1'b1; res_code = ERR_METADATA;
              end else begin
                ph_d = PH_FMT;
              end
            end else if (tag_q == TAG_DATA) begin
              res_v = 1'b1; ph_d = PH_DRAIN;
              if (!seen_q) begin
                res_code = ERR_MISSING;
              end else if (chan_q == '0 || rate_q == '0 || frame_q == '0) begin
                res_code = ERR_METADATA;
              end else if ((fmt_q != FMT_PCM && fmt_q != FMT_FLOAT) ||
                           chan_q > 16'(MAX_CHANNELS)) begin
                res_code = ERR_FORMAT;
              end else if ((fmt_q == FMT_PCM && bits_q != 16'd16 && bits_q != 16'd24 &&
                            bits_q != 16'd32) ||
                           (fmt_q == FMT_FLOAT && bits_q != 16'd32)) begin
                res_code = ERR_BITS;
              end else if (frame_q < {8'd0, used_new}) begin
                res_code = ERR_METADATA;
              end else begin
                off_d = '0; asm_d = '0; sum_d = '0; k_d = '0; used_d = used_new;
                if (len_d < {16'd0, frame_q}) begin
                  res_kind = KIND_END; res_code = ERR_HEADER; res_rate = rate_q;
                end else begin
                  res_v = 1'b0; ph_d = PH_DATA;
                end
              end
            end else if (len_d == '0) begin
              ph_d = PH_CHDR;
            end else begin
              ph_d = PH_SKIP; bc_d = len_d;
            end
          end
        end
      end
      PH_FMT: begin
        bc_d = bc_q + 32'd1;
        case (bc_q[3:0])
          4'd0:  fmt_d   = {8'd0, data_byte_i};
          4'd1:  fmt_d   = {data_byte_i, fmt_q[7:0]};
          4'd2:  chan_d  = {8'd0, data_byte_i};
          4'd3:  chan_d  = {data_byte_i, chan_q[7:0]};
          4'd4:  rate_d  = {24'd0, data_byte_i};
          4'd5:  rate_d  = {rate_q[31:16], data_byte_i, rate_q[7:0]};
          4'd6:  rate_d  = {rate_q[31:24], data_byte_i, rate_q[15:0]};
          4'd7:  rate_d  = {data_byte_i, rate_q[23:0]};
          4'd12: frame_d = {8'd0, data_byte_i};
          4'd13: frame_d = {data_byte_i, frame_q[7:0]};
          4'd14: bits_d  = {8'd0, data_byte_i};
          4'd15: bits_d  = {data_byte_i, bits_q[7:0]};
          default: ;
        endcase
        if (bc_q[3:0] == 4'd15) begin
          seen_d = 1'b1;
          if (len_q == 32'd16) begin
            ph_d = len_q[0] ? PH_PAD : PH_CHDR; bc_d = '0;
          end else begin
            ph_d = PH_SKIP; bc_d = len_q - 32'd16;
          end
        end
      end
      PH_SKIP: begin
        bc_d = bc_q - 32'd1;
        if (bc_d == '0) ph_d = len_q[0] ? PH_PAD : PH_CHDR;
      end
      PH_PAD: begin
        ph_d = PH_CHDR; bc_d = '0;
      end
      PH_DATA: begin
        len_d = len_q - 32'd1;
        if (off_q < {8'd0, used_q}) begin
          if (k_q == 2'd0) asm_d = {24'd0, data_byte_i};
          else asm_d = asm_q | ({24'd0, data_byte_i} << {k_q, 3'b000});
          if ({1'b0, k_q} == bps - 3'd1) begin
            sum_d = sum_q + SUM_W'(decode(asm_d, fmt_q, bits_q));
            asm_d = '0; k_d = '0;
          end else begin
            k_d = k_q + 2'd1;
          end
        end
        off_d = off_q + 16'd1;
        if (off_d >= frame_q) begin
          frame_done = 1'b1;
          frame_last = len_d < {16'd0, frame_q};
          sum_fin    = sum_d;
          off_d      = '0; sum_d = '0;
          if (frame_last) ph_d = PH_DRAIN;
        end
      end
      default: ;
    endcase
    div_req = frame_done;
    if (end_of_stream_i) begin
      if (ph_d != PH_DRAIN) begin
        div_req  = 1'b0; res_v = 1'b1; res_kind = KIND_ERROR; res_rate = '0;
        res_code = (ph_d == PH_HDR) ? ERR_HEADER : (ph_d == PH_DATA) ? ERR_TRUNC : ERR_MISSING;
      end
      ph_d = PH_HDR; bc_d = '0; len_d = '0; tag_d = '0; fmt_d = '0; chan_d = '0;
      rate_d = '0; frame_d = '0; bits_d = '0; seen_d = 1'b0; off_d = '0;
      asm_d = '0; sum_d = '0; k_d = '0; used_d = '0;
    end
  end

  assign status_o.div_need = div_req;
  assign status_o.div_done = dv_cnt_q == DCNT_W'(SUM_W - 1);
  assign status_o.out_full = out_valid_q;

  // one quotient bit per cycle
  assign dv_trial  = {dv_rem_q, dv_quo_q[SUM_W-1]};
  assign dv_bit    = dv_trial >= {2'b00, dv_den_q};
  assign dv_rem_nx = dv_bit ? (DEN_W+1)'(dv_trial - {2'b00, dv_den_q})
                            : dv_trial[DEN_W:0];
  assign dv_quo_nx = {dv_quo_q[SUM_W-2:0], dv_bit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_HDR; bc_q <= '0; len_q <= '0; tag_q <= '0; fmt_q <= '0;
      chan_q <= '0; rate_q <= '0; frame_q <= '0; bits_q <= '0; seen_q <= 1'b0;
      off_q <= '0; asm_q <= '0; sum_q <= '0; k_q <= '0; used_q <= '0;
      dv_cnt_q <= '0; out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        ph_q <= ph_d; bc_q <= bc_d; len_q <= len_d; tag_q <= tag_d; fmt_q <= fmt_d;
        chan_q <= chan_d; rate_q <= rate_d; frame_q <= frame_d; bits_q <= bits_d;
        seen_q <= seen_d; off_q <= off_d; asm_q <= asm_d; sum_q <= sum_d;
        k_q <= k_d; used_q <= used_d;
      end
      if (cmd_i.step && div_req) dv_cnt_q <= '0;
      else if (cmd_i.div_run) dv_cnt_q <= dv_cnt_q + DCNT_W'(1);
      if (cmd_i.step && res_v) out_valid_q <= 1'b1;
      else if (cmd_i.div_run && status_o.div_done) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && div_req) begin
      dv_quo_q  <= sum_fin[SUM_W-1] ? SUM_W'(-sum_fin) : SUM_W'(sum_fin);
      dv_neg_q  <= sum_fin[SUM_W-1];
      dv_rem_q  <= '0;
      dv_den_q  <= chan_q[DEN_W-1:0];
      dv_rate_q <= rate_q;
      dv_last_q <= frame_last;
    end else if (cmd_i.div_run) begin
      dv_quo_q <= dv_quo_nx;
      dv_rem_q <= dv_rem_nx;
    end
    if (cmd_i.step && res_v) begin
      kind_q <= res_kind; mono_q <= '0; rate_out_q <= res_rate;
      code_q <= res_code; last_q <= res_last;
    end else if (cmd_i.div_run && status_o.div_done) begin
      kind_q     <= KIND_SAMPLE;
      mono_q     <= dv_neg_q ? -dv_quo_nx[31:0] : dv_quo_nx[31:0];
      rate_out_q <= dv_rate_q;
      code_q     <= ERR_HEADER;
      last_q     <= dv_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign mono_sample_o = mono_q;
  assign rate_hz_o     = rate_out_q;
  assign error_code_o  = code_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_no_overwrite_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && res_v) |-> !out_valid_q) else $error("result over full slot");
  a_no_overwrite_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_run && status_o.div_done) |-> !out_valid_q)
    else $error("quotient over full slot");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !(res_v && div_req)) else $error("two results from one beat");
`endif

endmodule

>>> design/wav_stream_mono_downmix_top.sv
// RIFF/WAVE byte-stream parser with mono downmix. Feed the file one byte per
// beat; mark its final byte with end_of_stream_i, after which the parser
// rearms for the next file. The header tags are checked, unknown chunks and
// their pad bytes are skipped, the fmt chunk is captured, and the data chunk
// is decoded frame by frame (PCM 16/24/32 or float32, float saturated to
// [-1,1), NaN as 0). Each frame gives one Q1.31 channel average, truncated
// toward zero, with the sample rate; errors and files with no whole frame
// give one result with last_o set. Throughput: one byte per cycle while the
// result slot is free; each completed frame then runs the bit-serial divider
// that forms the channel average, during which no byte is accepted. A byte is
// taken only while the output register is empty.
module wav_stream_mono_downmix_top
  import wsmd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic signed [31:0] mono_sample_o,
  output logic [31:0] rate_hz_o,
  output logic [2:0]  error_code_o,
  output logic        last_o
);

  cmd_t    cmd;
  status_t status;
  logic [31:0] mono_raw;

  // sequence byte beats and divider runs
  wsmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // parse, decode, accumulate, divide and hold the result
  wsmd_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .mono_sample_o   (mono_raw),
    .rate_hz_o       (rate_hz_o),
    .error_code_o    (error_code_o),
    .last_o          (last_o)
  );

  assign mono_sample_o = $signed(mono_raw);

endmodule
